>>> sv/mcpf_pkg.sv
`timescale 1ns / 1ps
// shared types, codes and constants of the mqtt control packet framer
package mcpf_pkg;

    localparam int REQ_TYPE_W = 3;
    localparam int LEN_W      = 16;
    localparam int QOS_W      = 2;
    localparam int BYTE_W     = 8;

    // request codes
    localparam logic [REQ_TYPE_W-1:0] REQ_CONNECT = 3'd0;
    localparam logic [REQ_TYPE_W-1:0] REQ_SUB     = 3'd1;
    localparam logic [REQ_TYPE_W-1:0] REQ_UNSUB   = 3'd2;
    localparam logic [REQ_TYPE_W-1:0] REQ_PUB     = 3'd3;
    localparam logic [REQ_TYPE_W-1:0] REQ_PING    = 3'd4;
    localparam logic [REQ_TYPE_W-1:0] REQ_DISC    = 3'd5;
    localparam logic [REQ_TYPE_W-1:0] REQ_DATA    = 3'd6;

    localparam logic [QOS_W-1:0] QOS_MAX = 2'd2;
    localparam logic [QOS_W-1:0] QOS_BAD = 2'd3;

    // configuration port
    localparam int CFG_IDX_W    = 1;
    localparam int CFG_DATA_W   = 16;
    localparam int CONN_FLAGS_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_KEEP_ALIVE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CONN_FLAGS = 1'd1;
    localparam logic [CFG_DATA_W-1:0]   KEEP_ALIVE_RESET = 16'd60;
    localparam logic [CONN_FLAGS_W-1:0] CONN_FLAGS_RESET = 8'hC2;

    // packet bytes
    localparam logic [BYTE_W-1:0] BYTE_CONNECT = 8'h10;
    localparam logic [BYTE_W-1:0] BYTE_SUB     = 8'h82;
    localparam logic [BYTE_W-1:0] BYTE_UNSUB   = 8'hA2;
    localparam logic [BYTE_W-1:0] BYTE_PUB     = 8'h30;
    localparam logic [BYTE_W-1:0] BYTE_PING    = 8'hC0;
    localparam logic [BYTE_W-1:0] BYTE_DISC    = 8'hE0;
    localparam logic [BYTE_W-1:0] PROTO_LEVEL  = 8'h04;
    localparam logic [LEN_W-1:0]  PROTO_NAME_LEN = 16'd4;
    localparam logic [BYTE_W-1:0] CHAR_M = 8'h4D;
    localparam logic [BYTE_W-1:0] CHAR_Q = 8'h51;
    localparam logic [BYTE_W-1:0] CHAR_T = 8'h54;
    localparam logic [LEN_W-1:0]  SUB_PACKET_ID = 16'h0001;

    // remaining length: three groups of seven bits
    localparam int RL_GROUP_W = 7;
    localparam int REM_LEN_W  = 3 * RL_GROUP_W;
    localparam int REM_N_W    = 2;

    localparam logic [REM_LEN_W-1:0] RL_CONNECT_BASE = 21'd12;
    localparam logic [REM_LEN_W-1:0] RL_SUB_BASE     = 21'd5;
    localparam logic [REM_LEN_W-1:0] RL_UNSUB_BASE   = 21'd4;
    localparam logic [REM_LEN_W-1:0] RL_PUB_BASE     = 21'd2;
    localparam logic [REM_LEN_W-1:0] RL_PREFIX       = 21'd2;

    // byte position within one request's output run
    localparam int POS_W      = 5;
    localparam int BODY_IDX_W = 4;
    localparam logic [POS_W-1:0] BODY_N_CONNECT = 5'd12;
    localparam logic [POS_W-1:0] BODY_N_SUB     = 5'd4;
    localparam logic [POS_W-1:0] BODY_N_PUB     = 5'd2;

    localparam int CMDQ_DEPTH = 4;
    localparam int CMDQ_PTR_W = $clog2(CMDQ_DEPTH);
    localparam int CMDQ_CNT_W = $clog2(CMDQ_DEPTH + 1);

    typedef enum logic [2:0] {
        OP_BAD,
        OP_DATA,
        OP_CONNECT,
        OP_SUB,
        OP_UNSUB,
        OP_PUB,
        OP_PING,
        OP_DISC
    } t_op;

    typedef struct packed {
        t_op                    op;
        logic [BYTE_W-1:0]      lead;
        logic [REM_LEN_W-1:0]   rem_len;
        logic [REM_N_W-1:0]     rem_n;
        logic [LEN_W-1:0]       len1;
        logic                   word_en;
        logic [LEN_W-1:0]       word;
        logic                   byte_en;
        logic [BYTE_W-1:0]      tail_byte;
        logic                   fin;
    } t_cmd;

    typedef struct packed {
        logic full;
        logic empty;
    } t_cmdq_stat;

endpackage

>>> sv/mcpf_req_if.sv
`timescale 1ns / 1ps
// request channel interface
interface mcpf_req_if;
    import mcpf_pkg::*;

    logic                  valid;
    logic                  ready;
    logic [REQ_TYPE_W-1:0] req_type;
    logic [LEN_W-1:0]      first_len;
    logic [LEN_W-1:0]      second_len;
    logic [LEN_W-1:0]      third_len;
    logic [QOS_W-1:0]      qos_level;
    logic [BYTE_W-1:0]     data_byte;

    modport source (
        output valid, req_type, first_len, second_len, third_len, qos_level, data_byte,
        input  ready
    );
    modport sink (
        input  valid, req_type, first_len, second_len, third_len, qos_level, data_byte,
        output ready
    );
endinterface

>>> sv/mcpf_out_if.sv
`timescale 1ns / 1ps
// output byte channel interface
interface mcpf_out_if;
    import mcpf_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] out_byte;
    logic              run_last;
    logic              packet_end;
    logic              bad_request;

    modport source (
        output valid, out_byte, run_last, packet_end, bad_request,
        input  ready
    );
    modport sink (
        input  valid, out_byte, run_last, packet_end, bad_request,
        output ready
    );
endinterface

>>> sv/mcpf_front.sv
`timescale 1ns / 1ps
// request front end: packet state, classification and command build
module mcpf_front (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    mcpf_req_if.sink             i_req,
    input  mcpf_pkg::t_cmdq_stat i_stat,
    output logic                 o_push,
    output mcpf_pkg::t_cmd       o_cmd
);
    import mcpf_pkg::*;

    typedef enum logic [2:0] {
        K_IDLE,
        K_CONNECT,
        K_SUB,
        K_UNSUB,
        K_PUB
    } t_kind;

    typedef struct packed {
        t_kind             kind;
        logic [1:0]        fidx;
        logic [LEN_W-1:0]  left;
        logic [LEN_W-1:0]  pa;
        logic [LEN_W-1:0]  pb;
        logic [QOS_W-1:0]  qos;
        logic [LEN_W-1:0]  pid;
    } t_fstate;

    typedef struct packed {
        t_fstate           st;
        logic              word_en;
        logic [LEN_W-1:0]  word;
        logic              byte_en;
        logic [BYTE_W-1:0] tail_byte;
        logic              fin;
    } t_settle;

    t_fstate r_st;
    t_fstate n_st;
    t_cmd    cmd;
    logic    accept;

    // close finished fields and open the next one
    function automatic t_settle settle(input t_fstate s);
        t_settle          r;
        logic [LEN_W-1:0] id;
        r    = '0;
        r.st = s;
        id   = s.pid + 16'd1;
        if (s.kind != K_IDLE && s.left == '0) begin
            unique case (s.kind)
                K_CONNECT: begin
                    if (s.fidx == 2'd0 && s.pa != '0) begin
                        r.word_en = 1'b1;
                        r.word    = s.pa;
                        r.st.fidx = 2'd1;
                        r.st.left = s.pa;
                    end else if (s.fidx != 2'd2 && s.pb != '0) begin
                        r.word_en = 1'b1;
                        r.word    = s.pb;
                        r.st.fidx = 2'd2;
                        r.st.left = s.pb;
                    end else begin
                        r.fin = 1'b1;
                    end
                end
                K_SUB: begin
                    r.byte_en   = 1'b1;
                    r.tail_byte = BYTE_W'(s.qos);
                    r.fin       = 1'b1;
                end
                K_PUB: begin
                    if (s.fidx == 2'd0) begin
                        if (s.qos != '0) begin
                            if (id == '0) begin
                                id = 16'd1;
                            end
                            r.st.pid  = id;
                            r.word_en = 1'b1;
                            r.word    = id;
                        end
                        r.st.fidx = 2'd1;
                        r.st.left = s.pa;
                        r.fin     = (s.pa == '0);
                    end else begin
                        r.fin = 1'b1;
                    end
                end
                default: begin
                    r.fin = 1'b1;
                end
            endcase
            if (r.fin) begin
                r.st      = '0;
                r.st.kind = K_IDLE;
                r.st.pid  = (s.kind == K_PUB) ? r.st.pid : s.pid;
            end
        end
        if (r.fin && s.kind == K_PUB) begin
            r.st.pid = (s.fidx == 2'd0 && s.qos != '0) ? id : s.pid;
        end
        return r;
    endfunction

    always_comb begin
        logic [QOS_W-1:0]     qos_sat;
        logic [REM_LEN_W-1:0] l1;
        logic [REM_LEN_W-1:0] l2;
        logic [REM_LEN_W-1:0] l3;
        logic [REM_LEN_W-1:0] add2;
        logic [REM_LEN_W-1:0] add3;
        t_fstate              start;
        t_settle              res;
        logic                 use_settle;

        qos_sat    = (i_req.qos_level == QOS_BAD) ? QOS_MAX : i_req.qos_level;
        l1         = REM_LEN_W'(i_req.first_len);
        l2         = REM_LEN_W'(i_req.second_len);
        l3         = REM_LEN_W'(i_req.third_len);
        add2       = (i_req.second_len != '0) ? l2 + RL_PREFIX : '0;
        add3       = (i_req.third_len != '0) ? l3 + RL_PREFIX : '0;
        n_st       = r_st;
        start      = '0;
        start.kind = K_IDLE;
        start.pid  = r_st.pid;
        use_settle = 1'b0;
        cmd        = '0;
        cmd.op     = OP_BAD;
        cmd.len1   = i_req.first_len;

        if (i_req.req_type == REQ_DATA) begin
            if (r_st.kind != K_IDLE) begin
                cmd.op     = OP_DATA;
                cmd.lead   = i_req.data_byte;
                start      = r_st;
                start.left = r_st.left - 16'd1;
                use_settle = 1'b1;
            end
        end else if (r_st.kind == K_IDLE) begin
            unique case (i_req.req_type)
                REQ_CONNECT: begin
                    cmd.op      = OP_CONNECT;
                    cmd.lead    = BYTE_CONNECT;
                    cmd.rem_len = RL_CONNECT_BASE + l1 + add2 + add3;
                    start.kind  = K_CONNECT;
                    start.left  = i_req.first_len;
                    start.pa    = i_req.second_len;
                    start.pb    = i_req.third_len;
                    use_settle  = 1'b1;
                end
                REQ_SUB: begin
                    cmd.op      = OP_SUB;
                    cmd.lead    = BYTE_SUB;
                    cmd.rem_len = RL_SUB_BASE + l1;
                    start.kind  = K_SUB;
                    start.left  = i_req.first_len;
                    start.qos   = qos_sat;
                    use_settle  = 1'b1;
                end
                REQ_UNSUB: begin
                    cmd.op      = OP_UNSUB;
                    cmd.lead    = BYTE_UNSUB;
                    cmd.rem_len = RL_UNSUB_BASE + l1;
                    start.kind  = K_UNSUB;
                    start.left  = i_req.first_len;
                    use_settle  = 1'b1;
                end
                REQ_PUB: begin
                    cmd.op      = OP_PUB;
                    cmd.lead    = BYTE_PUB | BYTE_W'({qos_sat, 1'b0});
                    cmd.rem_len = RL_PUB_BASE + l1 + l2
                                + ((qos_sat != '0) ? RL_PREFIX : '0);
                    start.kind  = K_PUB;
                    start.left  = i_req.first_len;
                    start.pa    = i_req.second_len;
                    start.qos   = qos_sat;
                    use_settle  = 1'b1;
                end
                REQ_PING: begin
                    cmd.op   = OP_PING;
                    cmd.lead = BYTE_PING;
                    cmd.fin  = 1'b1;
                end
                REQ_DISC: begin
                    cmd.op   = OP_DISC;
                    cmd.lead = BYTE_DISC;
                    cmd.fin  = 1'b1;
                end
                default: begin
                    cmd.op = OP_BAD;
                end
            endcase
        end

        res = settle(start);
        if (use_settle) begin
            n_st          = res.st;
            cmd.word_en   = res.word_en;
            cmd.word      = res.word;
            cmd.byte_en   = res.byte_en;
            cmd.tail_byte = res.tail_byte;
            cmd.fin       = res.fin;
        end

        if (cmd.rem_len[REM_LEN_W-1:2*RL_GROUP_W] != '0) begin
            cmd.rem_n = 2'd3;
        end else if (cmd.rem_len[2*RL_GROUP_W-1:RL_GROUP_W] != '0) begin
            cmd.rem_n = 2'd2;
        end else begin
            cmd.rem_n = 2'd1;
        end
    end

    assign i_req.ready = !i_stat.full;
    assign accept      = i_req.valid && !i_stat.full;
    assign o_push      = accept;
    assign o_cmd       = cmd;

    // all-zero state is idle with no fields open
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (accept) begin
            r_st <= n_st;
        end
    end
endmodule

>>> sv/mcpf_cmdq.sv
`timescale 1ns / 1ps
// command queue between front end and byte sequencer
module mcpf_cmdq (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_push,
    input  mcpf_pkg::t_cmd       i_cmd,
    input  logic                 i_pop,
    output mcpf_pkg::t_cmd       o_head,
    output mcpf_pkg::t_cmdq_stat o_stat
);
    import mcpf_pkg::*;

    t_cmd                  r_mem [CMDQ_DEPTH];
    logic [CMDQ_PTR_W-1:0] r_wr;
    logic [CMDQ_PTR_W-1:0] r_rd;
    logic [CMDQ_CNT_W-1:0] r_cnt;
    logic                  do_push;
    logic                  do_pop;

    assign o_stat.full  = (r_cnt == CMDQ_CNT_W'(CMDQ_DEPTH));
    assign o_stat.empty = (r_cnt == '0);
    assign o_head       = r_mem[r_rd];
    assign do_push      = i_push && !o_stat.full;
    assign do_pop       = i_pop && !o_stat.empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (do_push) begin
                r_wr <= r_wr + CMDQ_PTR_W'(1);
            end
            if (do_pop) begin
                r_rd <= r_rd + CMDQ_PTR_W'(1);
            end
            if (do_push && !do_pop) begin
                r_cnt <= r_cnt + CMDQ_CNT_W'(1);
            end else if (do_pop && !do_push) begin
                r_cnt <= r_cnt - CMDQ_CNT_W'(1);
            end
        end
    end
endmodule

>>> sv/mcpf_back.sv
`timescale 1ns / 1ps
// byte sequencer: expands one command into its output bytes
module mcpf_back (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  mcpf_pkg::t_cmd                    i_head,
    input  mcpf_pkg::t_cmdq_stat              i_stat,
    input  logic [mcpf_pkg::CFG_DATA_W-1:0]   i_keep_alive,
    input  logic [mcpf_pkg::CONN_FLAGS_W-1:0] i_conn_flags,
    output logic                              o_pop,
    mcpf_out_if.source                        o_out
);
    import mcpf_pkg::*;

    logic [POS_W-1:0]  r_pos;
    logic              r_valid;
    logic [BYTE_W-1:0] r_byte;
    logic              r_last;
    logic              r_end;
    logic              r_bad;

    logic [BYTE_W-1:0] cur_byte;
    logic              cur_last;
    logic              load;

    function automatic logic [BYTE_W-1:0] body_byte(
        input t_op                     op,
        input logic [BODY_IDX_W-1:0]   k,
        input logic [CONN_FLAGS_W-1:0] flags,
        input logic [CFG_DATA_W-1:0]   ka,
        input logic [LEN_W-1:0]        l1
    );
        logic [BYTE_W-1:0] b;
        b = '0;
        unique case (op)
            OP_CONNECT: begin
                unique case (k)
                    4'd0:    b = PROTO_NAME_LEN[15:8];
                    4'd1:    b = PROTO_NAME_LEN[7:0];
                    4'd2:    b = CHAR_M;
                    4'd3:    b = CHAR_Q;
                    4'd4:    b = CHAR_T;
                    4'd5:    b = CHAR_T;
                    4'd6:    b = PROTO_LEVEL;
                    4'd7:    b = flags;
                    4'd8:    b = ka[15:8];
                    4'd9:    b = ka[7:0];
                    4'd10:   b = l1[15:8];
                    4'd11:   b = l1[7:0];
                    default: b = '0;
                endcase
            end
            OP_SUB, OP_UNSUB: begin
                unique case (k[1:0])
                    2'd0: b = SUB_PACKET_ID[15:8];
                    2'd1: b = SUB_PACKET_ID[7:0];
                    2'd2: b = l1[15:8];
                    2'd3: b = l1[7:0];
                endcase
            end
            OP_PUB: begin
                b = k[0] ? l1[7:0] : l1[15:8];
            end
            default: begin
                b = '0;
            end
        endcase
        return b;
    endfunction

    always_comb begin
        logic [POS_W-1:0]   body_n;
        logic [POS_W-1:0]   s_body;
        logic [POS_W-1:0]   s_word;
        logic [POS_W-1:0]   s_tb;
        logic [POS_W-1:0]   total;
        logic [POS_W-1:0]   k;
        logic [REM_N_W-1:0] rk;
        logic [RL_GROUP_W-1:0] grp;

        unique case (i_head.op)
            OP_CONNECT:       body_n = BODY_N_CONNECT;
            OP_SUB, OP_UNSUB: body_n = BODY_N_SUB;
            OP_PUB:           body_n = BODY_N_PUB;
            default:          body_n = '0;
        endcase
        s_body = POS_W'(1) + ((i_head.op == OP_BAD || i_head.op == OP_DATA)
                 ? POS_W'(0) : POS_W'(i_head.rem_n));
        s_word = s_body + body_n;
        s_tb   = s_word + (i_head.word_en ? POS_W'(2) : POS_W'(0));
        total  = s_tb + (i_head.byte_en ? POS_W'(1) : POS_W'(0));
        k      = '0;
        rk     = '0;
        grp    = '0;

        priority if (r_pos == '0) begin
            cur_byte = (i_head.op == OP_BAD) ? '0 : i_head.lead;
        end else if (r_pos < s_body) begin
            k  = r_pos - POS_W'(1);
            rk = k[REM_N_W-1:0];
            unique case (rk)
                2'd0:    grp = i_head.rem_len[RL_GROUP_W-1:0];
                2'd1:    grp = i_head.rem_len[2*RL_GROUP_W-1:RL_GROUP_W];
                2'd2:    grp = i_head.rem_len[REM_LEN_W-1:2*RL_GROUP_W];
                default: grp = '0;
            endcase
            cur_byte = {((rk + REM_N_W'(1)) != i_head.rem_n), grp};
        end else if (r_pos < s_word) begin
            k        = r_pos - s_body;
            cur_byte = body_byte(i_head.op, k[BODY_IDX_W-1:0], i_conn_flags,
                                 i_keep_alive, i_head.len1);
        end else if (r_pos < s_tb) begin
            k        = r_pos - s_word;
            cur_byte = k[0] ? i_head.word[7:0] : i_head.word[15:8];
        end else begin
            cur_byte = i_head.tail_byte;
        end

        cur_last = (r_pos == total - POS_W'(1));
    end

    assign load  = !i_stat.empty && (!r_valid || o_out.ready);
    assign o_pop = load && cur_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= '0;
            r_valid <= 1'b0;
        end else begin
            if (load) begin
                r_valid <= 1'b1;
                r_pos   <= cur_last ? '0 : r_pos + POS_W'(1);
            end else if (o_out.ready) begin
                r_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_byte <= cur_byte;
            r_last <= cur_last;
            r_end  <= cur_last && i_head.fin && (i_head.op != OP_BAD);
            r_bad  <= (i_head.op == OP_BAD);
        end
    end

    assign o_out.valid       = r_valid;
    assign o_out.out_byte    = r_byte;
    assign o_out.run_last    = r_last;
    assign o_out.packet_end  = r_end;
    assign o_out.bad_request = r_bad;
endmodule

>>> sv/mqtt_control_packet_framer.sv
`timescale 1ns / 1ps
// top level of the mqtt 3.1.1 control packet framer
// i_req takes one request per cycle unless the command queue is full: a packet
// start (connect, subscribe, unsubscribe, publish, ping, disconnect) or one
// string byte of the open field. o_out gives the framed packet one byte per
// cycle while the receiver is ready; run_last marks the final byte caused by a
// request, packet_end the byte that closes a packet, and bad_request a single
// zero byte for a rejected request. a request is classified in the cycle it
// is taken and queued as a command (four entries); the byte sequencer turns
// each command into 1 to 18 bytes. a taken request's command goes into the
// queue, and the sequencer then registers its first byte onto o_out once the
// output register is free. a data request without a field boundary yields a
// single byte, a start request its header bytes. i_req.ready drops only when
// the command queue is full. reset clears the packet state, packet id and
// queue, keep-alive goes to 60 and connect flags to 0xc2. a stalled receiver
// holds the output byte and backs up the queue; the user must write the config
// port only while idle, which the block itself does not enforce.
module mqtt_control_packet_framer (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_cfg_we,
    input  logic [mcpf_pkg::CFG_IDX_W-1:0]  i_cfg_idx,
    input  logic [mcpf_pkg::CFG_DATA_W-1:0] i_cfg_data,
    mcpf_req_if.sink                        i_req,
    mcpf_out_if.source                      o_out
);
    import mcpf_pkg::*;

    logic [CFG_DATA_W-1:0]   r_keep_alive;
    logic [CONN_FLAGS_W-1:0] r_conn_flags;

    logic       push;
    logic       pop;
    t_cmd       cmd;
    t_cmd       head;
    t_cmdq_stat stat;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_keep_alive <= KEEP_ALIVE_RESET;
            r_conn_flags <= CONN_FLAGS_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_KEEP_ALIVE: r_keep_alive <= i_cfg_data;
                CFG_CONN_FLAGS: r_conn_flags <= i_cfg_data[CONN_FLAGS_W-1:0];
            endcase
        end
    end

    mcpf_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (i_req),
        .i_stat  (stat),
        .o_push  (push),
        .o_cmd   (cmd)
    );

    mcpf_cmdq u_cmdq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_stat  (stat)
    );

    mcpf_back u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_head       (head),
        .i_stat       (stat),
        .i_keep_alive (r_keep_alive),
        .i_conn_flags (r_conn_flags),
        .o_pop        (pop),
        .o_out        (o_out)
    );
endmodule
